@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

    localparam int ADDR_BITS    = 24;
    localparam int ALLOC_DEPTH  = 64;
    localparam int HEADER_BYTES = 16;
    localparam int FREE_DEPTH   = 65;
    localparam int USED_W       = 25;
    localparam int CFG_W        = 24;
    localparam int BASE_W       = 16;

    // Index and count widths
    localparam int FIDX_W = $clog2(FREE_DEPTH);
    localparam int AIDX_W = $clog2(ALLOC_DEPTH);
    localparam int MAXD   = (FREE_DEPTH > ALLOC_DEPTH) ? FREE_DEPTH : ALLOC_DEPTH;
    localparam int CNT_W  = $clog2(MAXD + 1);
    localparam int SLOT_W = $clog2(ALLOC_DEPTH + 1);

    // Register reset values
    localparam logic [ADDR_BITS-1:0] REGION_RESET = ADDR_BITS'(1048576);
    localparam logic [BASE_W-1:0]    USED_RESET   = BASE_W'(64);
    localparam logic [BASE_W-1:0]    MINREM_RESET = BASE_W'(1024);

    // Register indexes
    localparam logic [1:0] REG_REGION_SIZE   = 2'd0;
    localparam logic [1:0] REG_USED_BASE     = 2'd1;
    localparam logic [1:0] REG_MIN_REMAINDER = 2'd2;

    // Actions
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOROOM    = 3'd1;
    localparam logic [2:0] ST_NOTALLOC  = 3'd2;
    localparam logic [2:0] ST_LOST      = 3'd3;
    localparam logic [2:0] ST_TABLEFULL = 3'd4;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] len;
    } ext_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] user;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] len;
    } aent_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_WR,
        OP_LOAD,
        OP_HEAP_RST,
        OP_FSCAN_A,
        OP_FSCAN_F,
        OP_ASCAN,
        OP_F_TAKE,
        OP_A_COMMIT,
        OP_F_COMMIT,
        OP_SHDN,
        OP_SHUP,
        OP_RESP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       set_st;
        logic [2:0] st;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       null_free;
        logic       fit_hit;
        logic       gt_hit;
        logic       look_hit;
        logic       ext_end;
        logic       look_end;
        logic       tail_short;
        logic       slot_done;
        logic       slot_full;
        logic       split;
        logic       count_full;
        logic       prev_touch;
        logic       next_touch;
        logic       up_done;
        logic       out_busy;
    } stat_t;

endpackage

@@ rtl/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator with an address-ordered free-extent table.
// Input channel (s_*): one transfer per request; s_action selects allocate,
// free or heap reset. Result channel (m_*): exactly one transfer per request,
// in request order, carrying status, granted user address, block size and
// the used-byte count after the request.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 region
// size, 1 used base, 2 minimum remainder); write only while idle. A new
// region size takes effect at the next heap reset.
// One request at a time. Allocate walks the extent table to the first
// fitting extent, then moves each extent above it down when that extent is
// taken whole. Free walks the allocated table until the pointer matches,
// then the extent table, then moves the extents above the insertion point.
// Each table is walked through its single read port.
// Reset: one cycle after aresetn releases, the extent table holds one extent
// covering the default region, and no block is allocated.
// Stall: a finished result waits in the output register; the next request
// is taken and worked on, and its result holds until the register drains.
module first_fit_heap_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [ffha_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [ffha_pkg::ADDR_BITS-1:0] s_req_size,
    input  logic [3:0]                     s_align_log2,
    input  logic [ffha_pkg::ADDR_BITS-1:0] s_free_addr,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [ffha_pkg::ADDR_BITS-1:0] m_user_addr,
    output logic [ffha_pkg::ADDR_BITS-1:0] m_block_size,
    output logic [ffha_pkg::USED_W-1:0]    m_used_bytes
);

    // Command and status between sequencer and datapath
    ffha_pkg::cmd_t  cmd;
    ffha_pkg::stat_t st;

    // Sequence the table walks, one request at a time
    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Hold the tables, counters and the output register
    ffha_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_action     (s_action),
        .s_req_size   (s_req_size),
        .s_align_log2 (s_align_log2),
        .s_free_addr  (s_free_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_user_addr  (m_user_addr),
        .m_block_size (m_block_size),
        .m_used_bytes (m_used_bytes),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

@@ rtl/ffha_ctrl.sv @@
module ffha_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ffha_pkg::stat_t st,
    output ffha_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_HRST,
        S_A_SCAN, S_A_CHECK, S_A_COMMIT,
        S_F_LOOK, S_F_TAKE, S_F_SCAN, S_F_COMMIT,
        S_SHDN, S_SHUP, S_RESP
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = ffha_pkg::OP_NONE;
        cmd.set_st = 1'b0;
        cmd.st     = ffha_pkg::ST_OK;
        unique case (state_reg)
            S_INIT: begin
                cmd.op     = ffha_pkg::OP_INIT_WR;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = ffha_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (st.act == ffha_pkg::ACT_ALLOC) begin
                    state_next = S_A_SCAN;
                end else if (st.act == ffha_pkg::ACT_FREE && !st.null_free) begin
                    state_next = S_F_LOOK;
                end else if (st.act == ffha_pkg::ACT_RESET) begin
                    state_next = S_HRST;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_HRST: begin
                cmd.op     = ffha_pkg::OP_HEAP_RST;
                state_next = S_RESP;
            end
            S_A_SCAN: begin
                cmd.op = ffha_pkg::OP_FSCAN_A;
                priority if (st.fit_hit) begin
                    state_next = S_A_CHECK;
                end else if (st.ext_end) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ffha_pkg::ST_NOROOM;
                    state_next = S_RESP;
                end
            end
            S_A_CHECK: begin
                priority if (st.tail_short) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ffha_pkg::ST_NOROOM;
                    state_next = S_RESP;
                end else if (st.slot_done) begin
                    if (st.slot_full) begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ffha_pkg::ST_TABLEFULL;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_A_COMMIT;
                    end
                end
            end
            S_A_COMMIT: begin
                cmd.op     = ffha_pkg::OP_A_COMMIT;
                state_next = st.split ? S_RESP : S_SHDN;
            end
            S_F_LOOK: begin
                cmd.op = ffha_pkg::OP_ASCAN;
                priority if (st.look_hit) begin
                    state_next = S_F_TAKE;
                end else if (st.look_end) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ffha_pkg::ST_NOTALLOC;
                    state_next = S_RESP;
                end
            end
            S_F_TAKE: begin
                cmd.op     = ffha_pkg::OP_F_TAKE;
                state_next = S_F_SCAN;
            end
            S_F_SCAN: begin
                cmd.op = ffha_pkg::OP_FSCAN_F;
                priority if (st.gt_hit && !st.count_full) begin
                    state_next = S_F_COMMIT;
                end else if (st.gt_hit || st.ext_end) begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ffha_pkg::ST_LOST;
                    state_next = S_RESP;
                end
            end
            S_F_COMMIT: begin
                cmd.op = ffha_pkg::OP_F_COMMIT;
                priority if (!st.prev_touch && !st.next_touch) begin
                    state_next = S_SHUP;
                end else if (st.prev_touch && st.next_touch) begin
                    state_next = S_SHDN;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_SHDN: begin
                cmd.op = ffha_pkg::OP_SHDN;
                if (st.ext_end) begin
                    state_next = S_RESP;
                end
            end
            S_SHUP: begin
                cmd.op = ffha_pkg::OP_SHUP;
                if (st.up_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!st.out_busy) begin
                    cmd.op     = ffha_pkg::OP_RESP;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ffha_dp.sv @@
module ffha_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [ffha_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [1:0]                           s_action,
    input  logic [ffha_pkg::ADDR_BITS-1:0]       s_req_size,
    input  logic [3:0]                           s_align_log2,
    input  logic [ffha_pkg::ADDR_BITS-1:0]       s_free_addr,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_status,
    output logic [ffha_pkg::ADDR_BITS-1:0]       m_user_addr,
    output logic [ffha_pkg::ADDR_BITS-1:0]       m_block_size,
    output logic [ffha_pkg::USED_W-1:0]          m_used_bytes,
    input  ffha_pkg::cmd_t                       cmd,
    output ffha_pkg::stat_t                      st
);

    localparam int AW  = ffha_pkg::ADDR_BITS;
    localparam int WW  = AW + 2;
    localparam int CW  = ffha_pkg::CNT_W;
    localparam int FW  = ffha_pkg::FIDX_W;
    localparam int AIW = ffha_pkg::AIDX_W;
    localparam int SW  = ffha_pkg::SLOT_W;
    localparam int UW  = ffha_pkg::USED_W;
    localparam int BW  = ffha_pkg::BASE_W;

    // Extent and allocation tables
    ffha_pkg::ext_t  fmem [0:ffha_pkg::FREE_DEPTH-1];
    ffha_pkg::aent_t amem [0:ffha_pkg::ALLOC_DEPTH-1];
    ffha_pkg::ext_t  frd_q;
    ffha_pkg::aent_t ard_q;

    logic                 fwe, fre;
    logic [FW-1:0]        fwaddr, fraddr;
    ffha_pkg::ext_t       fwdata;
    logic                 awe;

    logic [AW-1:0]        region_reg;
    logic [BW-1:0]        base_reg, minrem_reg;

    logic [1:0]           act_reg;
    logic [AW-1:0]        size_reg, faddr_reg;
    logic [3:0]           lg_reg;

    logic [CW-1:0]        count_reg, idx_reg, didx_reg, j_reg;
    logic                 pend_reg, run_reg;
    logic [SW-1:0]        slot_reg;
    logic [AIW-1:0]       hslot_reg;
    logic [ffha_pkg::ALLOC_DEPTH-1:0] valid_reg;
    logic [UW-1:0]        used_reg;

    ffha_pkg::ext_t       cur_reg, prev_reg, next_reg;
    logic [AW-1:0]        user_reg, adj_reg, rem_reg, bs_reg, bl_reg;
    logic                 last_reg;
    logic [2:0]           rstat_reg;
    logic [AW-1:0]        ruser_reg, rbsize_reg;

    logic                 m_valid_reg;
    logic [2:0]           m_status_reg;
    logic [AW-1:0]        m_user_reg, m_bsize_reg;
    logic [UW-1:0]        m_used_reg;

    logic [15:0]          amask;
    logic [WW-1:0]        usum, uaddr, adj_w;
    logic                 issue_cnt, issue_a, fits;
    logic [AW-1:0]        blen, merged_len;
    logic [AW:0]          blk_end;

    // Fit test on the extent coming out of the table
    always_comb begin
        amask = 16'((17'd1 << lg_reg) - 17'd1);
        usum  = {2'b00, frd_q.start} + WW'(ffha_pkg::HEADER_BYTES) + WW'(amask);
        uaddr = usum & ~(WW'(amask));
        adj_w = uaddr - {2'b00, frd_q.start} + {2'b00, size_reg};
        fits  = {2'b00, frd_q.len} >= adj_w;
    end

    assign issue_cnt  = idx_reg < count_reg;
    assign issue_a    = idx_reg < CW'(ffha_pkg::ALLOC_DEPTH);
    assign blen       = st.split ? adj_reg : cur_reg.len;
    assign merged_len = prev_reg.len + bl_reg;
    assign blk_end    = st.prev_touch ? ({1'b0, prev_reg.start} + {1'b0, merged_len})
                                      : ({1'b0, bs_reg} + {1'b0, bl_reg});

    always_comb begin
        st.act        = act_reg;
        st.null_free  = (faddr_reg == '0);
        st.fit_hit    = pend_reg && fits;
        st.gt_hit     = pend_reg && (frd_q.start > bs_reg);
        st.look_hit   = pend_reg && valid_reg[didx_reg[AIW-1:0]] &&
                        (ard_q.user == faddr_reg);
        st.ext_end    = !pend_reg && !issue_cnt;
        st.look_end   = !pend_reg && !issue_a;
        st.split      = rem_reg > AW'(minrem_reg);
        st.tail_short = last_reg && !st.split;
        st.slot_full  = (slot_reg == SW'(ffha_pkg::ALLOC_DEPTH));
        st.slot_done  = st.slot_full || !valid_reg[slot_reg[AIW-1:0]];
        st.count_full = count_reg >= CW'(ffha_pkg::FREE_DEPTH);
        st.prev_touch = (j_reg != '0) &&
                        (({1'b0, prev_reg.start} + {1'b0, prev_reg.len}) == {1'b0, bs_reg});
        st.next_touch = (blk_end == {1'b0, next_reg.start});
        st.up_done    = !run_reg && !pend_reg;
        st.out_busy   = m_valid_reg && !m_ready;
    end

    // Extent table port control
    always_comb begin
        fwe    = 1'b0;
        fre    = 1'b0;
        fwaddr = '0;
        fraddr = idx_reg[FW-1:0];
        fwdata = '0;
        unique case (cmd.op)
            ffha_pkg::OP_INIT_WR: begin
                fwe          = 1'b1;
                fwdata.len   = ffha_pkg::REGION_RESET;
            end
            ffha_pkg::OP_HEAP_RST: begin
                fwe          = 1'b1;
                fwdata.len   = region_reg;
            end
            ffha_pkg::OP_FSCAN_A, ffha_pkg::OP_FSCAN_F: begin
                fre = issue_cnt;
            end
            ffha_pkg::OP_A_COMMIT: begin
                fwe          = st.split;
                fwaddr       = j_reg[FW-1:0];
                fwdata.start = cur_reg.start + adj_reg;
                fwdata.len   = rem_reg;
            end
            ffha_pkg::OP_F_COMMIT: begin
                if (st.prev_touch) begin
                    fwe          = 1'b1;
                    fwaddr       = FW'(j_reg - CW'(1));
                    fwdata.start = prev_reg.start;
                    fwdata.len   = st.next_touch ? (merged_len + next_reg.len) : merged_len;
                end else if (st.next_touch) begin
                    fwe          = 1'b1;
                    fwaddr       = j_reg[FW-1:0];
                    fwdata.start = bs_reg;
                    fwdata.len   = bl_reg + next_reg.len;
                end
            end
            ffha_pkg::OP_SHDN: begin
                fre    = issue_cnt;
                fwe    = pend_reg;
                fwaddr = FW'(didx_reg - CW'(1));
                fwdata = frd_q;
            end
            ffha_pkg::OP_SHUP: begin
                fre = run_reg;
                if (pend_reg) begin
                    fwe    = 1'b1;
                    fwaddr = FW'(didx_reg + CW'(1));
                    fwdata = frd_q;
                end else if (!run_reg) begin
                    fwe          = 1'b1;
                    fwaddr       = j_reg[FW-1:0];
                    fwdata.start = bs_reg;
                    fwdata.len   = bl_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign awe = (cmd.op == ffha_pkg::OP_A_COMMIT);

    always_ff @(posedge aclk) begin
        if (fwe) begin
            fmem[fwaddr] <= fwdata;
        end
        if (fre) begin
            frd_q <= fmem[fraddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (awe) begin
            amem[slot_reg[AIW-1:0]] <= '{user: user_reg, start: cur_reg.start, len: blen};
        end
        ard_q <= amem[idx_reg[AIW-1:0]];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg  <= ffha_pkg::REGION_RESET;
            base_reg    <= ffha_pkg::USED_RESET;
            minrem_reg  <= ffha_pkg::MINREM_RESET;
            count_reg   <= CW'(1);
            used_reg    <= UW'(ffha_pkg::USED_RESET);
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            run_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ffha_pkg::REG_REGION_SIZE:   region_reg <= AW'(cfg_wdata);
                    ffha_pkg::REG_USED_BASE:     base_reg   <= BW'(cfg_wdata);
                    ffha_pkg::REG_MIN_REMAINDER: minrem_reg <= BW'(cfg_wdata);
                    default: begin
                    end
                endcase
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                ffha_pkg::OP_LOAD: begin
                    pend_reg <= 1'b0;
                end
                ffha_pkg::OP_HEAP_RST: begin
                    count_reg <= CW'(1);
                    valid_reg <= '0;
                    used_reg  <= UW'(base_reg);
                end
                ffha_pkg::OP_FSCAN_A, ffha_pkg::OP_FSCAN_F, ffha_pkg::OP_SHDN: begin
                    pend_reg <= issue_cnt;
                    if (cmd.op == ffha_pkg::OP_SHDN && st.ext_end) begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                ffha_pkg::OP_ASCAN: begin
                    pend_reg <= issue_a;
                end
                ffha_pkg::OP_F_TAKE: begin
                    valid_reg[hslot_reg] <= 1'b0;
                    used_reg             <= used_reg - UW'(bl_reg);
                    pend_reg             <= 1'b0;
                end
                ffha_pkg::OP_A_COMMIT: begin
                    valid_reg[slot_reg[AIW-1:0]] <= 1'b1;
                    used_reg                     <= used_reg + UW'(blen);
                    pend_reg                     <= 1'b0;
                end
                ffha_pkg::OP_F_COMMIT: begin
                    pend_reg <= 1'b0;
                    run_reg  <= 1'b1;
                end
                ffha_pkg::OP_SHUP: begin
                    pend_reg <= run_reg;
                    if (run_reg) begin
                        run_reg <= (idx_reg != j_reg);
                    end
                    if (st.up_done) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                ffha_pkg::OP_RESP: begin
                    m_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (!slot_reg[SW-1] || !st.slot_full) begin
            if (!st.slot_full && valid_reg[slot_reg[AIW-1:0]]) begin
                slot_reg <= slot_reg + SW'(1);
            end
        end
        unique case (cmd.op)
            ffha_pkg::OP_LOAD: begin
                act_reg    <= s_action;
                size_reg   <= s_req_size;
                lg_reg     <= s_align_log2;
                faddr_reg  <= s_free_addr;
                idx_reg    <= '0;
                slot_reg   <= '0;
                rstat_reg  <= ffha_pkg::ST_OK;
                ruser_reg  <= '0;
                rbsize_reg <= '0;
            end
            ffha_pkg::OP_FSCAN_A: begin
                idx_reg  <= idx_reg + CW'(issue_cnt);
                didx_reg <= idx_reg;
                if (st.fit_hit) begin
                    j_reg    <= didx_reg;
                    cur_reg  <= frd_q;
                    user_reg <= uaddr[AW-1:0];
                    adj_reg  <= adj_w[AW-1:0];
                    rem_reg  <= frd_q.len - adj_w[AW-1:0];
                    last_reg <= (didx_reg + CW'(1)) == count_reg;
                end
            end
            ffha_pkg::OP_FSCAN_F: begin
                idx_reg  <= idx_reg + CW'(issue_cnt);
                didx_reg <= idx_reg;
                if (pend_reg && !st.gt_hit) begin
                    prev_reg <= frd_q;
                end
                if (st.gt_hit) begin
                    j_reg    <= didx_reg;
                    next_reg <= frd_q;
                end
            end
            ffha_pkg::OP_ASCAN: begin
                idx_reg  <= idx_reg + CW'(issue_a);
                didx_reg <= idx_reg;
                if (st.look_hit) begin
                    hslot_reg <= didx_reg[AIW-1:0];
                    bs_reg    <= ard_q.start;
                    bl_reg    <= ard_q.len;
                end
            end
            ffha_pkg::OP_F_TAKE: begin
                idx_reg    <= '0;
                rbsize_reg <= bl_reg;
            end
            ffha_pkg::OP_A_COMMIT: begin
                idx_reg    <= j_reg + CW'(1);
                ruser_reg  <= user_reg;
                rbsize_reg <= blen;
            end
            ffha_pkg::OP_F_COMMIT: begin
                idx_reg <= (st.prev_touch && st.next_touch) ? (j_reg + CW'(1))
                                                           : (count_reg - CW'(1));
            end
            ffha_pkg::OP_SHDN: begin
                idx_reg  <= idx_reg + CW'(issue_cnt);
                didx_reg <= idx_reg;
            end
            ffha_pkg::OP_SHUP: begin
                if (run_reg) begin
                    idx_reg  <= idx_reg - CW'(1);
                    didx_reg <= idx_reg;
                end
            end
            ffha_pkg::OP_RESP: begin
                m_status_reg <= rstat_reg;
                m_user_reg   <= ruser_reg;
                m_bsize_reg  <= rbsize_reg;
                m_used_reg   <= used_reg;
            end
            default: begin
            end
        endcase
        if (cmd.set_st) begin
            rstat_reg <= cmd.st;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_user_addr  = m_user_reg;
    assign m_block_size = m_bsize_reg;
    assign m_used_bytes = m_used_reg;

endmodule

@@ bench/first_fit_heap_allocator_core_tb.sv @@
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    // Selector value that the block must ignore
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int HOLD_CYCLES    = 600;
    localparam logic [63:0] ADDR_MASK = 64'hFF_FFFF;
    localparam logic [63:0] USED_MASK = 64'h1FF_FFFF;

    typedef struct packed {
        logic [1:0]           act;
        logic [ADDR_BITS-1:0] size;
        logic [3:0]           align;
        logic [ADDR_BITS-1:0] addr;
    } heap_req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] user;
        logic [ADDR_BITS-1:0] bsize;
        logic [USED_W-1:0]    used;
    } heap_rsp_t;

    typedef struct packed {
        heap_req_t req;
        logic      typed;
        heap_rsp_t rsp;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = 2'd0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action = ACT_NOP;
    logic [ADDR_BITS-1:0] s_req_size = '0;
    logic [3:0]           s_align_log2 = '0;
    logic [ADDR_BITS-1:0] s_free_addr = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [ADDR_BITS-1:0] m_user_addr;
    logic [ADDR_BITS-1:0] m_block_size;
    logic [USED_W-1:0]    m_used_bytes;

    first_fit_heap_allocator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_req_size(s_req_size), .s_align_log2(s_align_log2),
        .s_free_addr(s_free_addr),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_user_addr(m_user_addr), .m_block_size(m_block_size),
        .m_used_bytes(m_used_bytes)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the allocator: configuration, free extents, block table
    logic [63:0] sh_region = 64'd1048576;
    logic [63:0] sh_used_base = 64'd64;
    logic [63:0] sh_min_rem = 64'd1024;
    logic [63:0] ext_start [FREE_DEPTH];
    logic [63:0] ext_len [FREE_DEPTH];
    int          ext_count;
    logic [63:0] blk_user [ALLOC_DEPTH];
    logic [63:0] blk_start [ALLOC_DEPTH];
    logic [63:0] blk_len [ALLOC_DEPTH];
    logic        blk_live [ALLOC_DEPTH];
    logic [63:0] used_ctr;

    heap_rsp_t   pending_rsp [$];
    logic [63:0] live_ptrs [$];
    int          mismatches = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;
    int          stall_cnt = 0;

    function automatic void heap_clear();
        for (int k = 0; k < FREE_DEPTH; k++) begin
            ext_start[k] = 0;
            ext_len[k] = 0;
        end
        ext_len[0] = sh_region & ADDR_MASK;
        ext_count = 1;
        for (int k = 0; k < ALLOC_DEPTH; k++) blk_live[k] = 1'b0;
        used_ctr = sh_used_base & USED_MASK;
    endfunction

    function automatic void ext_remove(int i);
        for (int k = i; k + 1 < ext_count; k++) begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k] = ext_len[k + 1];
        end
        ext_count--;
    endfunction

    function automatic void ext_insert(int i, logic [63:0] st, logic [63:0] ln);
        for (int k = ext_count; k > i; k--) begin
            ext_start[k] = ext_start[k - 1];
            ext_len[k] = ext_len[k - 1];
        end
        ext_start[i] = st;
        ext_len[i] = ln;
        ext_count++;
    endfunction

    // Advance the shadow heap by one request and return its result
    function automatic heap_rsp_t heap_predict(heap_req_t r);
        heap_rsp_t   o;
        logic [63:0] al, usr, adj, rem, bst, bln;
        int          i, slot, j;
        bit          hit;
        o = '0;
        if (r.act == ACT_ALLOC) begin
            al = 64'd1 << r.align;
            usr = 0;
            adj = 0;
            hit = 0;
            for (i = 0; i < ext_count; i++) begin
                usr = (ext_start[i] + HEADER_BYTES + al - 1) & ~(al - 1);
                adj = usr - ext_start[i] + r.size;
                if (ext_len[i] >= adj) begin
                    hit = 1;
                    break;
                end
            end
            if (!hit) begin
                o.status = ST_NOROOM;
            end else begin
                rem = ext_len[i] - adj;
                for (slot = 0; slot < ALLOC_DEPTH; slot++) if (!blk_live[slot]) break;
                if (i + 1 == ext_count && rem <= sh_min_rem) begin
                    o.status = ST_NOROOM;
                end else if (slot >= ALLOC_DEPTH) begin
                    o.status = ST_TABLEFULL;
                end else begin
                    bst = ext_start[i];
                    if (rem > sh_min_rem) begin
                        bln = adj;
                        ext_start[i] = (bst + adj) & ADDR_MASK;
                        ext_len[i] = rem & ADDR_MASK;
                    end else begin
                        bln = ext_len[i];
                        ext_remove(i);
                    end
                    blk_live[slot] = 1'b1;
                    blk_user[slot] = usr & ADDR_MASK;
                    blk_start[slot] = bst;
                    blk_len[slot] = bln & ADDR_MASK;
                    used_ctr = (used_ctr + bln) & USED_MASK;
                    o.status = ST_OK;
                    o.user = usr[ADDR_BITS-1:0];
                    o.bsize = bln[ADDR_BITS-1:0];
                end
            end
        end else if (r.act == ACT_FREE && r.addr != 0) begin
            for (slot = 0; slot < ALLOC_DEPTH; slot++)
                if (blk_live[slot] && blk_user[slot] == r.addr) break;
            if (slot >= ALLOC_DEPTH) begin
                o.status = ST_NOTALLOC;
            end else begin
                bst = blk_start[slot];
                bln = blk_len[slot];
                blk_live[slot] = 1'b0;
                used_ctr = (used_ctr - bln) & USED_MASK;
                o.bsize = bln[ADDR_BITS-1:0];
                for (j = 0; j < ext_count; j++) if (ext_start[j] > bst) break;
                if (j >= ext_count || ext_count >= FREE_DEPTH) begin
                    o.status = ST_LOST;
                end else begin
                    ext_insert(j, bst, bln);
                    if (j > 0 && ext_start[j - 1] + ext_len[j - 1] == bst) begin
                        ext_len[j - 1] = (ext_len[j - 1] + bln) & ADDR_MASK;
                        ext_remove(j);
                        j--;
                    end
                    if (j + 1 < ext_count && ext_start[j] + ext_len[j] == ext_start[j + 1]) begin
                        ext_len[j] = (ext_len[j] + ext_len[j + 1]) & ADDR_MASK;
                        ext_remove(j + 1);
                    end
                    o.status = ST_OK;
                end
            end
        end else if (r.act == ACT_RESET) begin
            heap_clear();
        end
        o.used = used_ctr[USED_W-1:0];
        return o;
    endfunction

    // Offer one request, hold it until the transfer, and queue its result
    task automatic issue_req(input heap_req_t r, input bit typed, input heap_rsp_t tv,
                             output heap_rsp_t pr);
        pr = heap_predict(r);
        pending_rsp.push_back(typed ? tv : pr);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        end
        s_valid      <= 1'b1;
        s_action     <= r.act;
        s_req_size   <= r.size;
        s_align_log2 <= r.align;
        s_free_addr  <= r.addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send(input heap_req_t r, output heap_rsp_t pr);
        issue_req(r, 1'b0, '0, pr);
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_REGION_SIZE) sh_region = val & 64'hFF_FFFF;
        else if (idx == REG_USED_BASE) sh_used_base = val & 64'hFFFF;
        else sh_min_rem = val & 64'hFFFF;
    endtask

    // Write all three registers, then reset the heap so the region applies
    task automatic set_phase(input logic [63:0] reg_region, input logic [63:0] reg_base,
                             input logic [63:0] reg_minrem);
        heap_rsp_t pr;
        drain();
        cfg_write(REG_REGION_SIZE, reg_region);
        cfg_write(REG_USED_BASE, reg_base);
        cfg_write(REG_MIN_REMAINDER, reg_minrem);
        send('{act: ACT_RESET, size: '0, align: '0, addr: '0}, pr);
        live_ptrs.delete();
    endtask

    function automatic heap_req_t random_req();
        heap_req_t r;
        int        pick, k;
        r.act   = ACT_ALLOC;
        r.align = 4'($urandom_range(12));
        r.addr  = ADDR_BITS'($urandom);
        k = $urandom_range(99);
        if (k < 70) r.size = ADDR_BITS'($urandom_range(600));
        else if (k < 92) r.size = ADDR_BITS'($urandom_range(40000));
        else r.size = ADDR_BITS'($urandom);
        pick = $urandom_range(99);
        if (pick < 40 && live_ptrs.size() != 0) begin
            r.act  = ACT_FREE;
            r.addr = live_ptrs[$urandom_range(live_ptrs.size() - 1)][ADDR_BITS-1:0];
        end else if (pick < 48) begin
            r.act = ACT_FREE;
        end else if (pick < 50) begin
            r.act  = ACT_FREE;
            r.addr = '0;
        end else if (pick < 52) begin
            r.act = ACT_NOP;
        end else if (pick < 53) begin
            r.act = ACT_RESET;
        end
        return r;
    endfunction

    // Keep the list of granted pointers in step with the shadow heap
    function automatic void track_live(heap_req_t r, heap_rsp_t pr);
        if (r.act == ACT_RESET) live_ptrs.delete();
        else if (r.act == ACT_ALLOC && pr.status == ST_OK) live_ptrs.push_back(pr.user);
        else if (r.act == ACT_FREE && (pr.status == ST_OK || pr.status == ST_LOST))
            foreach (live_ptrs[k]) if (live_ptrs[k] == r.addr) begin
                live_ptrs.delete(k);
                break;
            end
    endfunction

    int sent_total = 0;

    task automatic random_run(input int count);
        heap_req_t r;
        heap_rsp_t pr;
        for (int n = 0; n < count; n++) begin
            // Idle mix: receiver-heavy idle, then sender-heavy idle, then back to back
            if (sent_total < 500) begin
                tx_idle = 37;
                rx_idle = 71;
            end else if (sent_total < 1000) begin
                tx_idle = 71;
                rx_idle = 37;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (sent_total == 1100) hold_req <= 1'b1;
            r = random_req();
            send(r, pr);
            track_live(r, pr);
            sent_total++;
        end
    endtask

    // Fragment the heap into 63 blocks and 64 free extents; the holes grow
    // so that no later request fits an older one
    task automatic fragment_run();
        heap_rsp_t   pr;
        logic [63:0] big_ptrs [$];
        for (int k = 0; k < ALLOC_DEPTH; k++) begin
            send('{act: ACT_ALLOC, size: ADDR_BITS'(16 + 16 * k), align: '0, addr: '0}, pr);
            live_ptrs.push_back(pr.user);
            send('{act: ACT_ALLOC, size: ADDR_BITS'(4080), align: '0, addr: '0}, pr);
            big_ptrs.push_back(pr.user);
            send('{act: ACT_FREE, size: '0, align: '0, addr: live_ptrs.pop_back()}, pr);
        end
        // Take the first hole whole, which fills the block table, then free two blocks
        send('{act: ACT_ALLOC, size: '0, align: '0, addr: '0}, pr);
        send('{act: ACT_FREE, size: '0, align: '0, addr: big_ptrs[0][ADDR_BITS-1:0]}, pr);
        send('{act: ACT_FREE, size: '0, align: '0, addr: big_ptrs[1][ADDR_BITS-1:0]}, pr);
        send('{act: ACT_RESET, size: '0, align: '0, addr: '0}, pr);
    endtask

    dir_row_t dir_tbl [$];

    function automatic void add_row(logic [1:0] act, logic [63:0] size, int align,
                                    logic [63:0] addr, bit typed, logic [2:0] st,
                                    logic [63:0] usr, logic [63:0] bsz, logic [63:0] used);
        dir_row_t d;
        d.req   = '{act: act, size: size[ADDR_BITS-1:0], align: 4'(align),
                    addr: addr[ADDR_BITS-1:0]};
        d.typed = typed;
        d.rsp   = '{status: st, user: usr[ADDR_BITS-1:0], bsize: bsz[ADDR_BITS-1:0],
                    used: used[USED_W-1:0]};
        dir_tbl.push_back(d);
    endfunction

    initial begin
        heap_rsp_t pr;
        heap_clear();
        // Reset values: 1 MiB region, 64 used, remainder limit 1024
        add_row(ACT_FREE,  0, 0, 0, 1, ST_OK, 0, 0, 64);                 // null free
        add_row(ACT_NOP,   0, 0, 0, 1, ST_OK, 0, 0, 64);                 // unused selector
        add_row(ACT_FREE,  0, 0, 24'h123, 1, ST_NOTALLOC, 0, 0, 64);     // unknown pointer
        add_row(ACT_ALLOC, 0, 0, 0, 1, ST_OK, 16, 16, 80);
        add_row(ACT_ALLOC, 24'hFF_FFFF, 12, 0, 1, ST_NOROOM, 0, 0, 80);
        add_row(ACT_ALLOC, 100, 12, 0, 1, ST_OK, 4096, 4180, 4260);
        add_row(ACT_FREE,  0, 0, 4096, 1, ST_OK, 0, 4180, 80);
        add_row(ACT_FREE,  0, 0, 16, 1, ST_OK, 0, 16, 64);
        // Tail without a large enough remainder, then one byte less
        add_row(ACT_ALLOC, 1048576 - 16 - 1024, 0, 0, 1, ST_NOROOM, 0, 0, 64);
        add_row(ACT_ALLOC, 1048576 - 16 - 1025, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(ACT_FREE,  0, 0, 16, 0, ST_OK, 0, 0, 0);
        // Exact fit inside takes the whole hole
        add_row(ACT_ALLOC, 0, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(ACT_ALLOC, 0, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(ACT_FREE,  0, 0, 16, 0, ST_OK, 0, 0, 0);
        add_row(ACT_ALLOC, 0, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(ACT_ALLOC, 5, 15, 0, 0, ST_OK, 0, 0, 0);
        add_row(ACT_ALLOC, 24'hAAAAAA, 7, 0, 0, ST_OK, 0, 0, 0);
        add_row(ACT_FREE,  0, 0, 24'hFF_FFFF, 0, ST_OK, 0, 0, 0);
        add_row(ACT_RESET, 0, 0, 0, 1, ST_OK, 0, 0, 64);                 // heap reset

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle = 37;
        rx_idle = 71;
        foreach (dir_tbl[k]) issue_req(dir_tbl[k].req, dir_tbl[k].typed, dir_tbl[k].rsp, pr);

        set_phase(64'd1048576, 64'd64, 64'd1024);
        fragment_run();
        random_run(420);
        set_phase(64'hFF_FFFF, 64'hFFFF, 64'd0);
        random_run(420);
        set_phase(64'd1, 64'd0, 64'hFFFF);
        random_run(60);
        set_phase(64'd5000, 64'd100, 64'd16);
        random_run(200);
        set_phase(64'd1048576, 64'd64, 64'd1024);
        random_run(350);
        drain();

        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // Long receiver hold-off so the block fills up and stalls its input
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest pending result
    always @(posedge aclk) begin
        heap_rsp_t want, got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{status: m_status, user: m_user_addr, bsize: m_block_size,
                        used: m_used_bytes};
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d addr %h size %h used %h",
                                 got.status, got.user, got.bsize, got.used);
                end else begin
                    want = pending_rsp.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected status %0d addr %h size %h",
                                      " used %h, got status %0d addr %h size %h used %h"},
                                     want.status, want.user, want.bsize, want.used,
                                     got.status, got.user, got.bsize, got.used);
                    end
                end
            end
            m_ready <= !(hold_req && !hold_done) && ($urandom_range(99) >= rx_idle);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || pending_rsp.size() == 0)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
